>>> rtl/motor_safety_supervisor_unit_assert.svh
// Assertion macros shared by the supervisor RTL.
// MSS_ASSERT checks a property at each rising clock edge outside reset.
// MSS_ASSERT_ANY checks a property at each rising clock edge, reset included.
`ifndef MOTOR_SAFETY_SUPERVISOR_UNIT_ASSERT_SVH
`define MOTOR_SAFETY_SUPERVISOR_UNIT_ASSERT_SVH

`ifndef ASSERT_OFF
`define MSS_ASSERT(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);
`define MSS_ASSERT_ANY(label, prop, msg) \
    label: assert property (@(posedge i_clk) prop) else $error(msg);
`else
`define MSS_ASSERT(label, prop, msg)
`define MSS_ASSERT_ANY(label, prop, msg)
`endif

`endif

>>> rtl/mss_pkg.sv
package mss_pkg;

    // Request codes.
    localparam logic [1:0] OP_INIT   = 2'd0;
    localparam logic [1:0] OP_ARM    = 2'd1;
    localparam logic [1:0] OP_DISARM = 2'd2;
    localparam logic [1:0] OP_TICK   = 2'd3;

    // Safety modes.
    localparam logic [2:0] MODE_DISARMED = 3'd0;
    localparam logic [2:0] MODE_ARMED    = 3'd1;
    localparam logic [2:0] MODE_FALLEN   = 3'd2;
    localparam logic [2:0] MODE_WARN     = 3'd3;
    localparam logic [2:0] MODE_STOP     = 3'd4;
    localparam logic [2:0] MODE_BOOT     = 3'd5;

    // Battery classes.
    localparam logic [1:0] BAT_UNKNOWN = 2'd0;
    localparam logic [1:0] BAT_NORMAL  = 2'd1;
    localparam logic [1:0] BAT_WARN    = 2'd2;
    localparam logic [1:0] BAT_STOP    = 2'd3;

    // Configuration register indexes.
    localparam logic [2:0] CFG_FALL_PITCH_LIMIT    = 3'd0;
    localparam logic [2:0] CFG_FALL_DEBOUNCE_TICKS = 3'd1;
    localparam logic [2:0] CFG_STARTUP_MUTE_MS     = 3'd2;
    localparam logic [2:0] CFG_BOOT_WINDOW_MS      = 3'd3;
    localparam logic [2:0] CFG_LOW_BAT_PWM_LIMIT   = 3'd4;
    localparam logic [2:0] CFG_FALL_BRAKE_MS       = 3'd5;
    localparam logic [2:0] CFG_LOW_BAT_BRAKE_MS    = 3'd6;

    localparam logic [9:0] FULL_PWM = 10'd1000;

    localparam int IN_DATA_W  = 56;
    localparam int OUT_DATA_W = 40;

    typedef struct packed {
        logic [1:0]         operation;
        logic [31:0]        now_ms;
        logic               attitude_ok;
        logic signed [15:0] pitch;
        logic [1:0]         battery_class;
        logic               battery_boot_ok;
    } t_item;

    typedef struct packed {
        logic [14:0] fall_pitch_limit;
        logic [7:0]  fall_debounce_ticks;
        logic [15:0] startup_mute_ms;
        logic [15:0] boot_window_ms;
        logic [9:0]  low_bat_pwm_limit;
        logic [15:0] fall_brake_ms;
        logic [15:0] low_bat_brake_ms;
    } t_cfg;

    typedef struct packed {
        logic [2:0]  mode;
        logic [7:0]  debounce_count;
        logic [31:0] grace_deadline;
        logic [31:0] boot_deadline;
        logic        boot_finished;
        logic        arm_pending;
        logic        motor_enabled;
        logic [9:0]  pwm_limit_now;
    } t_state;

    typedef struct packed {
        logic [2:0]  safety_mode;
        logic        request_accepted;
        logic        may_drive;
        logic        motor_on;
        logic [9:0]  pwm_cap;
        logic        brake_fire;
        logic [15:0] brake_len_ms;
        logic        grace_active;
    } t_result;

    // A deadline is still running while (deadline - now) is positive as a signed value.
    function automatic logic still_running(input logic [31:0] deadline,
                                           input logic [31:0] now);
        logic [31:0] diff;
        diff = deadline - now;
        return (diff != 32'd0) && !diff[31];
    endfunction

endpackage

>>> rtl/mss_step.sv
module mss_step (
    input  mss_pkg::t_item   i_item,
    input  mss_pkg::t_cfg    i_cfg,
    input  mss_pkg::t_state  i_state,
    output mss_pkg::t_state  o_state,
    output mss_pkg::t_result o_result
);
    import mss_pkg::*;

    t_state      w_st;
    logic        w_go;
    logic [2:0]  w_target;
    logic        w_force_off;
    logic        w_brake;
    logic [15:0] w_brake_len;
    logic        w_accepted;
    logic        w_fallen;
    logic [15:0] w_mag;
    logic [7:0]  w_count_inc;

    assign w_mag = i_item.pitch[15] ? 16'(-i_item.pitch) : 16'(i_item.pitch);
    assign w_count_inc = (i_state.debounce_count < i_cfg.fall_debounce_ticks) ?
                         i_state.debounce_count + 8'd1 : i_state.debounce_count;

    always_comb begin
        w_st        = i_state;
        w_go        = 1'b0;
        w_target    = i_state.mode;
        w_force_off = 1'b0;
        w_brake     = 1'b0;
        w_brake_len = 16'd0;
        w_accepted  = 1'b1;
        w_fallen    = 1'b0;

        unique case (i_item.operation)
            OP_INIT: begin
                w_st.debounce_count = 8'd0;
                w_st.arm_pending    = 1'b0;
                w_st.grace_deadline = i_item.now_ms + {16'd0, i_cfg.startup_mute_ms};
                if (!i_state.boot_finished) begin
                    w_st.mode          = MODE_BOOT;
                    w_st.boot_deadline = i_item.now_ms + {16'd0, i_cfg.boot_window_ms};
                end else begin
                    w_st.mode = MODE_DISARMED;
                end
                w_st.pwm_limit_now = FULL_PWM;
                w_st.motor_enabled = 1'b0;
                w_brake            = 1'b1;
            end
            OP_ARM: begin
                if (i_state.mode == MODE_BOOT) begin
                    w_st.arm_pending = 1'b1;
                end else if (i_state.mode == MODE_STOP) begin
                    w_accepted = 1'b0;
                end else begin
                    w_st.debounce_count = 8'd0;
                    w_go     = 1'b1;
                    w_target = MODE_ARMED;
                end
            end
            OP_DISARM: begin
                w_go     = 1'b1;
                w_target = MODE_DISARMED;
            end
            default: begin
                if (i_state.mode == MODE_BOOT) begin
                    if (!still_running(i_state.boot_deadline, i_item.now_ms) ||
                        i_item.battery_boot_ok) begin
                        w_st.boot_finished  = 1'b1;
                        w_st.debounce_count = 8'd0;
                        w_st.arm_pending    = 1'b0;
                        w_go = 1'b1;
                        if (i_item.battery_class == BAT_STOP) begin
                            w_target = MODE_STOP;
                        end else if (i_state.arm_pending) begin
                            w_target = MODE_ARMED;
                        end else begin
                            w_target = MODE_DISARMED;
                        end
                    end
                end else begin
                    if (still_running(i_state.grace_deadline, i_item.now_ms) ||
                        !i_item.attitude_ok) begin
                        w_st.debounce_count = 8'd0;
                    end else if (w_mag > {1'b0, i_cfg.fall_pitch_limit}) begin
                        w_st.debounce_count = w_count_inc;
                        w_fallen = (w_count_inc >= i_cfg.fall_debounce_ticks);
                    end else begin
                        w_st.debounce_count = 8'd0;
                    end

                    priority if (i_item.battery_class == BAT_STOP) begin
                        w_go     = 1'b1;
                        w_target = MODE_STOP;
                    end else if (i_state.mode == MODE_STOP) begin
                        // Recovery from a stop comes back in warn with the motor still off.
                        w_go        = 1'b1;
                        w_target    = MODE_WARN;
                        w_force_off = 1'b1;
                    end else if (i_state.mode == MODE_DISARMED) begin
                        if (i_item.battery_class == BAT_WARN) begin
                            w_st.mode = MODE_WARN;
                        end
                    end else if (w_fallen) begin
                        w_go     = 1'b1;
                        w_target = MODE_FALLEN;
                    end else if (i_item.battery_class == BAT_WARN) begin
                        if (i_state.mode == MODE_ARMED || i_state.mode == MODE_WARN) begin
                            w_go     = 1'b1;
                            w_target = MODE_WARN;
                        end
                    end else if (i_item.battery_class == BAT_NORMAL) begin
                        if (i_state.mode == MODE_WARN && i_state.motor_enabled) begin
                            w_go     = 1'b1;
                            w_target = MODE_ARMED;
                        end
                    end else begin
                        w_go = 1'b0;
                    end
                end
            end
        endcase

        // Mode change side effects; a change to the current mode does nothing.
        if (w_go && (w_target != i_state.mode)) begin
            w_st.mode = w_target;
            if (w_target == MODE_DISARMED || w_target == MODE_FALLEN) begin
                w_brake            = 1'b1;
                w_brake_len        = i_cfg.fall_brake_ms;
                w_st.motor_enabled = 1'b0;
            end else if (w_target == MODE_STOP) begin
                w_brake            = 1'b1;
                w_brake_len        = i_cfg.low_bat_brake_ms;
                w_st.motor_enabled = 1'b0;
            end else if (w_target == MODE_ARMED) begin
                w_st.pwm_limit_now = FULL_PWM;
                w_st.motor_enabled = 1'b1;
            end else if (w_target == MODE_WARN) begin
                w_st.pwm_limit_now = i_cfg.low_bat_pwm_limit;
                w_st.motor_enabled = 1'b1;
            end
        end
        if (w_force_off) begin
            w_st.motor_enabled = 1'b0;
        end
    end

    assign o_state = w_st;

    assign o_result.safety_mode      = w_st.mode;
    assign o_result.request_accepted = w_accepted;
    assign o_result.may_drive        = (w_st.mode == MODE_ARMED) || (w_st.mode == MODE_WARN);
    assign o_result.motor_on         = w_st.motor_enabled;
    assign o_result.pwm_cap          = w_st.pwm_limit_now;
    assign o_result.brake_fire       = w_brake;
    assign o_result.brake_len_ms     = w_brake_len;
    assign o_result.grace_active     = still_running(w_st.grace_deadline, i_item.now_ms);

endmodule

>>> rtl/motor_safety_supervisor_unit.sv
// Motor safety supervisor. Each input transfer carries one request (init, arm,
// disarm or tick, in s_tuser) and yields exactly one result transfer holding the
// safety mode, the arm acceptance, the drive permission, the motor enable, the
// PWM cap, an optional brake pulse and the startup fall-mute status. A request
// is captured in an input register, evaluated against the supervisor state by
// combinational compare-and-select logic, and the result is held in an output
// register; the supervisor state updates as the result is written. The block
// sustains one transfer per clock cycle while the result side accepts; a
// request passes through the input register and then the output register before
// its result transfer can happen. It keeps taking requests while a result
// waits for the downstream side, up to the one item held in the input register.
// Deadlines are compared by signed wrap-around difference of 32-bit millisecond
// time. Configuration registers are written through the plain write port and
// must be changed only while no request is in flight.
module motor_safety_supervisor_unit (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // Configuration write port.
    input  logic        i_cfg_we,
    input  logic [2:0]  i_cfg_idx,
    input  logic [15:0] i_cfg_data,
    // Request stream.
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    // Fields from bit 0 up: now_ms[31:0], attitude_ok[32], pitch[48:33],
    // battery_class[50:49], battery_boot_ok[51], zero fill [55:52].
    input  logic [55:0] i_s_tdata,
    // Fields from bit 0 up: operation[1:0].
    input  logic [1:0]  i_s_tuser,
    // Result stream.
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    // Fields from bit 0 up: safety_mode[2:0], request_accepted[3], may_drive[4],
    // motor_on[5], pwm_cap[15:6], brake_fire[16], brake_len_ms[32:17],
    // grace_active[33], zero fill [39:34].
    output logic [39:0] o_m_tdata
);
    import mss_pkg::*;

    `include "motor_safety_supervisor_unit_assert.svh"

    logic    r_in_valid;
    t_item   r_in;
    logic    r_out_valid;
    t_result r_out;
    t_state  r_state;
    t_cfg    r_cfg;

    t_item   w_item;
    t_state  n_state;
    t_result n_result;
    logic    w_advance;

    assign w_item.operation       = i_s_tuser;
    assign w_item.now_ms          = i_s_tdata[31:0];
    assign w_item.attitude_ok     = i_s_tdata[32];
    assign w_item.pitch           = i_s_tdata[48:33];
    assign w_item.battery_class   = i_s_tdata[50:49];
    assign w_item.battery_boot_ok = i_s_tdata[51];

    // The held request moves on whenever the result register is free or being emptied.
    assign w_advance  = r_in_valid && (!r_out_valid || i_m_tready);
    assign o_s_tready = !r_in_valid || w_advance;

    mss_step u_step (
        .i_item   (r_in),
        .i_cfg    (r_cfg),
        .i_state  (r_state),
        .o_state  (n_state),
        .o_result (n_result)
    );

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.fall_pitch_limit    <= 15'd6000;
            r_cfg.fall_debounce_ticks <= 8'd3;
            r_cfg.startup_mute_ms     <= 16'd1000;
            r_cfg.boot_window_ms      <= 16'd5000;
            r_cfg.low_bat_pwm_limit   <= 10'd600;
            r_cfg.fall_brake_ms       <= 16'd200;
            r_cfg.low_bat_brake_ms    <= 16'd200;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_FALL_PITCH_LIMIT:    r_cfg.fall_pitch_limit    <= i_cfg_data[14:0];
                CFG_FALL_DEBOUNCE_TICKS: r_cfg.fall_debounce_ticks <= i_cfg_data[7:0];
                CFG_STARTUP_MUTE_MS:     r_cfg.startup_mute_ms     <= i_cfg_data;
                CFG_BOOT_WINDOW_MS:      r_cfg.boot_window_ms      <= i_cfg_data;
                CFG_LOW_BAT_PWM_LIMIT:   r_cfg.low_bat_pwm_limit   <= i_cfg_data[9:0];
                CFG_FALL_BRAKE_MS:       r_cfg.fall_brake_ms       <= i_cfg_data;
                CFG_LOW_BAT_BRAKE_MS:    r_cfg.low_bat_brake_ms    <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    // Input register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_s_tready) begin
            r_in_valid <= i_s_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_s_tready && i_s_tvalid) begin
            r_in <= w_item;
        end
    end

    // Supervisor state changes exactly when a request is turned into a result.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state.mode           <= MODE_DISARMED;
            r_state.debounce_count <= 8'd0;
            r_state.grace_deadline <= 32'd0;
            r_state.boot_deadline  <= 32'd0;
            r_state.boot_finished  <= 1'b0;
            r_state.arm_pending    <= 1'b0;
            r_state.motor_enabled  <= 1'b0;
            r_state.pwm_limit_now  <= FULL_PWM;
        end else if (w_advance) begin
            r_state <= n_state;
        end
    end

    // Result register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_advance) begin
            r_out_valid <= 1'b1;
        end else if (i_m_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_advance) begin
            r_out <= n_result;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = {6'd0, r_out.grace_active, r_out.brake_len_ms, r_out.brake_fire,
                         r_out.pwm_cap, r_out.motor_on, r_out.may_drive,
                         r_out.request_accepted, r_out.safety_mode};

    `MSS_ASSERT_ANY(a_reset_empties, !i_rst_n |=> !r_out_valid && !r_in_valid, "reset left a transfer pending")
    `MSS_ASSERT(a_state_held, (r_in_valid && !w_advance) |=> $stable(r_state), "state changed with no result taken")
    `MSS_ASSERT(a_brake_len_zero, (r_out_valid && !r_out.brake_fire) |-> (r_out.brake_len_ms == 16'd0), "brake length without a brake")
    `MSS_ASSERT(a_motor_needs_drive, (r_out_valid && r_out.motor_on) |-> r_out.may_drive, "motor enabled in a mode that may not drive")

endmodule
